FILE: rtl/lkr_pkg.sv
// Package with sizes, status and operation codes for the LRU-K frame replacer.
`timescale 1ns / 1ps
package lkr_pkg;

  // Frames tracked by the replacer and the deepest access history kept per frame.
  localparam int FRAME_SLOTS = 16;
  localparam int MAX_K = 4;

  typedef enum logic [1:0] {
    KIND_ACCESS = 2'd0,
    KIND_SET_EVICT = 2'd1,
    KIND_REMOVE = 2'd2,
    KIND_EVICT = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK = 3'd0,
    ST_NO_VICTIM = 3'd1,
    ST_RANGE = 3'd2,
    ST_UNTRACKED = 3'd3,
    ST_PINNED = 3'd4
  } status_e;

  localparam logic [0:0] CFG_HISTORY_K = 1'b0;
  localparam logic [0:0] CFG_FRAMES_IN_USE = 1'b1;

endpackage

FILE: rtl/lru_k_frame_replacer.sv
// Top level of the LRU-K frame replacer: control, frame flags and stamp memory.
// Access, flag change and remove pass through the read, apply and output states;
// evict scans the stamps of every frame, reading one frame per cycle, then drops the victim.
// One item is in work at a time; the stamp memory read port paces the evict scan.
// The output register frees the input side as soon as a result is loaded.
// Reset clears all flags, counts and the clock, and sets history depth 2 and 16 frames in use.
`timescale 1ns / 1ps
module lru_k_frame_replacer #(
  parameter int STAMP_BITS = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] kind_i,
  input  logic [3:0] frame_i,
  input  logic       evictable_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] status_o,
  output logic [3:0] victim_frame_o,
  output logic [4:0] evictable_count_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [0:0] cfg_index_i,
  input  logic [4:0] cfg_data_i
);
  import lkr_pkg::*;

  localparam int FW = (FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1;
  localparam int KW = (MAX_K > 1) ? $clog2(MAX_K) : 1;
  localparam int CW = $clog2(MAX_K + 1);
  localparam int NW = $clog2(FRAME_SLOTS + 1);
  localparam int AW = FW + KW;
  localparam logic [STAMP_BITS-1:0] STAMP_MAX = '1;

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_APPLY, S_SCAN, S_DROP, S_OUT
  } state_e;

  state_e state_q;
  logic [2:0] hist_k_q;
  logic [4:0] in_use_q;
  logic [FRAME_SLOTS-1:0] tracked_q, may_evict_q;
  logic [CW-1:0] cnt_q [FRAME_SLOTS];
  logic [KW-1:0] head_q [FRAME_SLOTS];
  logic [STAMP_BITS-1:0] clock_q;
  logic [NW-1:0] total_q;
  logic [STAMP_BITS-1:0] mem [2**AW];
  logic [STAMP_BITS-1:0] rd_q;

  logic [1:0] kind_q;
  logic [FW-1:0] fr_q;
  logic want_q;
  logic [FW:0] scan_q;        // frame whose stamp read is issued in the current scan step
  logic scan_vld_q;
  logic found_q, best_inf_q;
  logic [FW-1:0] best_q;
  logic [STAMP_BITS-1:0] best_key_q;
  logic [2:0] k_eff;
  logic out_v_q;
  status_e st_q;
  logic [3:0] vic_q;
  logic [4:0] cnt_o_q;
  status_e res_st_q;
  logic [3:0] res_vic_q;

  logic [AW-1:0] rd_addr;
  logic rd_en;
  logic wr_en;
  logic [AW-1:0] wr_addr;

  assign k_eff = (hist_k_q == 3'd0) ? 3'd1 :
                 ({29'd0, hist_k_q} > MAX_K) ? 3'(MAX_K) : hist_k_q;
  assign in_stall_o = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_v_q;
  assign status_o = st_q;
  assign victim_frame_o = vic_q;
  assign evictable_count_o = cnt_o_q;

  // Address of the back-th most recent stamp for a scanned frame.
  logic [FW-1:0] sf;
  logic inf_sel;
  logic [KW-1:0] back;
  assign sf = scan_q[FW-1:0];
  assign inf_sel = {{(8-CW){1'b0}}, cnt_q[sf]} < {5'd0, k_eff};
  assign back = inf_sel ? KW'(1) : KW'(k_eff);
  always_comb begin
    rd_en = (state_q == S_SCAN) && !scan_q[FW];
    rd_addr = {sf, KW'(head_q[sf] - back)};
    if (MAX_K == 1) rd_addr = {sf, {KW{1'b0}}};
  end

  logic in_rng, in_arr;
  assign in_arr = {{(32-FW){1'b0}}, fr_q} < FRAME_SLOTS;
  assign in_rng = in_arr && ({{(32-FW){1'b0}}, fr_q} < {27'd0, in_use_q});

  assign wr_en = (state_q == S_APPLY) && (kind_q == KIND_ACCESS) && in_rng;
  assign wr_addr = {fr_q, tracked_q[fr_q] ? head_q[fr_q] : {KW{1'b0}}};

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= clock_q;
    if (rd_en) rd_q <= mem[rd_addr];
  end

  // Candidate held for the frame read in the previous cycle.
  logic c_inf_q;
  logic [FW-1:0] c_f_q;
  logic [STAMP_BITS-1:0] key;
  logic better;
  assign key = c_inf_q ? rd_q : clock_q - rd_q;
  assign better = !found_q || (c_inf_q && !best_inf_q) ||
                  (c_inf_q && best_inf_q && key < best_key_q) ||
                  (!c_inf_q && !best_inf_q && key > best_key_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      hist_k_q <= 3'd2;
      in_use_q <= 5'd16;
      tracked_q <= '0;
      may_evict_q <= '0;
      for (int i = 0; i < FRAME_SLOTS; i++) begin
        cnt_q[i] <= '0;
        head_q[i] <= '0;
      end
      clock_q <= '0;
      total_q <= '0;
      out_v_q <= 1'b0;
      st_q <= ST_OK;
      vic_q <= '0;
      cnt_o_q <= '0;
      res_st_q <= ST_OK;
      res_vic_q <= '0;
      kind_q <= KIND_ACCESS;
      fr_q <= '0;
      want_q <= 1'b0;
      scan_q <= '0;
      scan_vld_q <= 1'b0;
      found_q <= 1'b0;
      best_inf_q <= 1'b0;
      best_q <= '0;
      best_key_q <= '0;
      c_inf_q <= 1'b0;
      c_f_q <= '0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_HISTORY_K: hist_k_q <= cfg_data_i[2:0];
          CFG_FRAMES_IN_USE: in_use_q <= cfg_data_i;
          default: ;
        endcase
      end
      // A finished result moves into the output register once that register is free.
      if (state_q == S_OUT && (!out_v_q || !out_stall_i)) begin
        out_v_q <= 1'b1;
        st_q <= res_st_q;
        vic_q <= res_vic_q;
        cnt_o_q <= 5'(total_q);
      end else if (out_v_q && !out_stall_i) begin
        out_v_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i && !in_stall_o) begin
            kind_q <= kind_i;
            fr_q <= FW'(frame_i);
            want_q <= evictable_i;
            state_q <= (kind_i == KIND_EVICT) ? S_SCAN : S_READ;
            scan_q <= '0;
            scan_vld_q <= 1'b0;
            found_q <= 1'b0;
            best_inf_q <= 1'b0;
            best_key_q <= '0;
            best_q <= '0;
          end
        end
        S_READ: state_q <= S_APPLY;
        S_APPLY: begin
          res_vic_q <= '0;
          case (kind_q)
            KIND_ACCESS: begin
              if (!in_rng) res_st_q <= ST_RANGE;
              else begin
                res_st_q <= ST_OK;
                if (!tracked_q[fr_q]) begin
                  tracked_q[fr_q] <= 1'b1;
                  may_evict_q[fr_q] <= 1'b0;
                  cnt_q[fr_q] <= CW'(1);
                  head_q[fr_q] <= KW'(1);
                end else begin
                  head_q[fr_q] <= KW'(head_q[fr_q] + KW'(1));
                  if ({{(8-CW){1'b0}}, cnt_q[fr_q]} < MAX_K)
                    cnt_q[fr_q] <= cnt_q[fr_q] + CW'(1);
                end
                if (clock_q != STAMP_MAX) clock_q <= clock_q + 1'b1;
              end
            end
            KIND_SET_EVICT: begin
              if (!in_rng) res_st_q <= ST_RANGE;
              else if (!tracked_q[fr_q]) res_st_q <= ST_UNTRACKED;
              else begin
                res_st_q <= ST_OK;
                if (may_evict_q[fr_q] != want_q) begin
                  may_evict_q[fr_q] <= want_q;
                  if (want_q) total_q <= total_q + 1'b1;
                  else if (total_q != '0) total_q <= total_q - 1'b1;
                end
              end
            end
            default: begin
              if (!in_arr) res_st_q <= ST_RANGE;
              else if (tracked_q[fr_q] && !may_evict_q[fr_q]) res_st_q <= ST_PINNED;
              else begin
                res_st_q <= ST_OK;
                if (tracked_q[fr_q]) begin
                  tracked_q[fr_q] <= 1'b0;
                  may_evict_q[fr_q] <= 1'b0;
                  cnt_q[fr_q] <= '0;
                  head_q[fr_q] <= '0;
                  if (total_q != '0) total_q <= total_q - 1'b1;
                end
              end
            end
          endcase
          state_q <= S_OUT;
        end
        S_SCAN: begin
          // Stage one issues a read; stage two compares the returned stamp.
          if (!scan_q[FW]) begin
            scan_vld_q <= tracked_q[sf] && may_evict_q[sf];
            c_inf_q <= inf_sel;
            c_f_q <= sf;
            scan_q <= (scan_q == (FW+1)'(FRAME_SLOTS - 1)) ? {1'b1, {FW{1'b0}}} :
                      scan_q + (FW+1)'(1);
          end else begin
            scan_vld_q <= 1'b0;
            state_q <= S_DROP;
          end
          if (scan_vld_q && better) begin
            found_q <= 1'b1;
            best_inf_q <= c_inf_q;
            best_q <= c_f_q;
            best_key_q <= key;
          end
        end
        S_DROP: begin
          if (!found_q) begin
            res_st_q <= ST_NO_VICTIM;
            res_vic_q <= '0;
          end else begin
            res_st_q <= ST_OK;
            res_vic_q <= 4'(best_q);
            tracked_q[best_q] <= 1'b0;
            may_evict_q[best_q] <= 1'b0;
            cnt_q[best_q] <= '0;
            head_q[best_q] <= '0;
            if (total_q != '0) total_q <= total_q - 1'b1;
          end
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (!out_v_q || !out_stall_i) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_vic_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && st_q != ST_OK |-> vic_q == '0) else $error("victim without ok");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_IDLE |-> in_stall_o) else $error("accepting while busy");
  a_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {{(32-NW){1'b0}}, total_q} <= FRAME_SLOTS) else $error("count overflow");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && out_stall_i |=> out_v_q && $stable(st_q)) else $error("result lost");
endmodule

FILE: dv/lru_k_frame_replacer_tb.sv
// Self-checking testbench for the LRU-K frame replacer with a built-in predictor.
`timescale 1ns / 1ps
module lru_k_frame_replacer_tb;
  import lkr_pkg::*;

  typedef struct {
    kind_e kind;
    logic [3:0] frame;
    logic evictable;
  } req_t;

  typedef struct {
    status_e status;
    logic [3:0] victim;
    logic [4:0] count;
  } answer_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [1:0] kind_i = '0;
  logic [3:0] frame_i = '0;
  logic evictable_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [2:0] status_o;
  logic [3:0] victim_frame_o;
  logic [4:0] evictable_count_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [0:0] cfg_index_i = '0;
  logic [4:0] cfg_data_i = '0;

  lru_k_frame_replacer dut (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Shadow copy of the replacer state.
  logic [2:0] sh_k;
  logic [4:0] sh_frames;
  bit sh_tracked[16];
  bit sh_evictable[16];
  logic [31:0] sh_stamps[16][4];
  int sh_count[16];
  int sh_head[16];
  logic [31:0] sh_clock;
  int sh_total;

  req_t req_q[$];
  answer_t answer_q[$];
  int errors = 0;
  int results_seen = 0;
  int gap_left = 0;
  int burst_left = 0;
  int hold_left = 0;

  task automatic report(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic void forget_frame(input int f);
    sh_tracked[f] = 0;
    sh_evictable[f] = 0;
    sh_count[f] = 0;
    sh_head[f] = 0;
  endfunction

  function automatic logic [31:0] stamp_ago(input int f, input int back);
    return sh_stamps[f][(sh_head[f] + 4 - back) % 4];
  endfunction

  function automatic void predict_answer(input req_t r);
    answer_t a;
    int f;
    int k;
    bit in_use;
    bit found;
    bit best_inf;
    bit inf;
    int best;
    logic [31:0] best_key;
    logic [31:0] key;
    f = r.frame;
    a.status = ST_OK;
    a.victim = '0;
    in_use = f < sh_frames;
    found = 0;
    best_inf = 0;
    best = 0;
    best_key = '0;
    case (r.kind)
      KIND_ACCESS: begin
        if (!in_use) a.status = ST_RANGE;
        else begin
          if (!sh_tracked[f]) begin
            forget_frame(f);
            sh_tracked[f] = 1;
          end
          sh_stamps[f][sh_head[f]] = sh_clock;
          sh_head[f] = (sh_head[f] + 1) % 4;
          if (sh_count[f] < 4) sh_count[f]++;
          if (sh_clock != 32'hFFFF_FFFF) sh_clock++;
        end
      end
      KIND_SET_EVICT: begin
        if (!in_use) a.status = ST_RANGE;
        else if (!sh_tracked[f]) a.status = ST_UNTRACKED;
        else if (sh_evictable[f] != r.evictable) begin
          sh_evictable[f] = r.evictable;
          if (r.evictable) sh_total++;
          else if (sh_total > 0) sh_total--;
        end
      end
      KIND_REMOVE: begin
        if (sh_tracked[f]) begin
          if (!sh_evictable[f]) a.status = ST_PINNED;
          else begin
            forget_frame(f);
            if (sh_total > 0) sh_total--;
          end
        end
      end
      default: begin
        k = (sh_k == 0) ? 1 : (sh_k > 4) ? 4 : sh_k;
        for (int i = 0; i < 16; i++) begin
          if (sh_tracked[i] && sh_evictable[i]) begin
            inf = sh_count[i] < k;
            key = inf ? stamp_ago(i, 1) : sh_clock - stamp_ago(i, k);
            if (!found || (inf && !best_inf) || (inf && best_inf && key < best_key) ||
                (!inf && !best_inf && key > best_key)) begin
              found = 1;
              best_inf = inf;
              best = i;
              best_key = key;
            end
          end
        end
        if (!found) a.status = ST_NO_VICTIM;
        else begin
          a.victim = 4'(best);
          forget_frame(best);
          if (sh_total > 0) sh_total--;
        end
      end
    endcase
    a.count = 5'(sh_total);
    answer_q = {answer_q, a};
  endfunction

  // Request driver: bursts of beats separated by random gaps.
  always @(posedge clk_i) begin : drv_blk
    bit took;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      took = in_valid_i && !in_stall_o;
      if (took) begin
        predict_answer(req_q[0]);
        void'(req_q.pop_front());
      end
      if (!in_valid_i || took) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (req_q.size() > 0) begin
          in_valid_i <= 1'b1;
          kind_i <= req_q[0].kind;
          frame_i <= req_q[0].frame;
          evictable_i <= req_q[0].evictable;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom % 3 == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver stall pattern.
  always @(posedge clk_i) begin : mon_blk
    answer_t a;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (answer_q.size() == 0) begin
          report("result beat with nothing expected");
        end else begin
          a = answer_q.pop_front();
          if (status_o !== a.status)
            report($sformatf("status %0d, expected %0d", status_o, a.status));
          if (victim_frame_o !== a.victim)
            report($sformatf("victim %0d, expected %0d", victim_frame_o, a.victim));
          if (evictable_count_o !== a.count)
            report($sformatf("count %0d, expected %0d", evictable_count_o, a.count));
        end
        results_seen++;
        // One long hold-off so the block backs up into its input.
        if (results_seen == 500) hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        case ((results_seen / 128) % 3)
          0: out_stall_i <= 1'b0;
          1: out_stall_i <= ($urandom % 4 == 0);
          default: out_stall_i <= ($urandom % 3 != 0);
        endcase
      end
    end
  end

  task automatic write_reg(input logic [0:0] idx, input logic [4:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_HISTORY_K) sh_k = data[2:0];
    else sh_frames = data;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic add_req(input kind_e kind, input int f, input bit ev);
    req_t r;
    r.kind = kind;
    r.frame = 4'(f);
    r.evictable = ev;
    req_q = {req_q, r};
  endtask

  task automatic add_random(input int n);
    int roll;
    int top;
    kind_e kind;
    for (int i = 0; i < n; i++) begin
      roll = $urandom_range(0, 99);
      kind = (roll < 45) ? KIND_ACCESS : (roll < 70) ? KIND_SET_EVICT :
             (roll < 80) ? KIND_REMOVE : KIND_EVICT;
      top = (sh_frames == 0) ? 0 : (sh_frames > 16) ? 15 : sh_frames - 1;
      // Mostly frames in use, with some out-of-range noise.
      add_req(kind, ($urandom % 8 == 0) ? $urandom_range(0, 15) : $urandom_range(0, top),
              ($urandom % 4 != 0));
    end
  endtask

  // Let every queued beat go through and every answer come back.
  task automatic drain();
    do @(posedge clk_i);
    while (req_q.size() != 0 || in_valid_i || answer_q.size() != 0);
    repeat (40) @(posedge clk_i);
  endtask

  initial begin
    sh_k = 3'd2;
    sh_frames = 5'd16;
    sh_clock = '0;
    sh_total = 0;
    for (int i = 0; i < 16; i++) forget_frame(i);
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty evict, untracked frames, pinned removal, flag repeats.
    add_req(KIND_EVICT, 0, 0);
    add_req(KIND_SET_EVICT, 3, 1);
    add_req(KIND_REMOVE, 4, 0);
    add_req(KIND_ACCESS, 0, 0);
    add_req(KIND_ACCESS, 15, 1);
    add_req(KIND_ACCESS, 0, 0);
    add_req(KIND_REMOVE, 0, 0);
    add_req(KIND_SET_EVICT, 0, 1);
    add_req(KIND_SET_EVICT, 0, 1);
    add_req(KIND_SET_EVICT, 15, 1);
    add_req(KIND_EVICT, 0, 0);
    add_req(KIND_EVICT, 0, 0);
    add_req(KIND_ACCESS, 5, 0);
    add_req(KIND_SET_EVICT, 5, 1);
    add_req(KIND_SET_EVICT, 5, 0);
    add_req(KIND_SET_EVICT, 5, 0);
    add_req(KIND_REMOVE, 5, 0);
    add_req(KIND_SET_EVICT, 5, 1);
    add_req(KIND_REMOVE, 5, 0);
    add_req(KIND_REMOVE, 5, 0);
    add_req(KIND_EVICT, 0, 0);
    drain();

    add_random(250);
    drain();
    write_reg(CFG_HISTORY_K, 5'd1);
    write_reg(CFG_FRAMES_IN_USE, 5'd8);
    add_req(KIND_ACCESS, 8, 0);
    add_req(KIND_SET_EVICT, 12, 1);
    add_req(KIND_REMOVE, 12, 0);
    add_random(200);
    drain();
    write_reg(CFG_HISTORY_K, 5'h1C);
    write_reg(CFG_FRAMES_IN_USE, 5'd1);
    add_random(60);
    drain();
    write_reg(CFG_HISTORY_K, 5'd0);
    write_reg(CFG_FRAMES_IN_USE, 5'd0);
    add_random(20);
    drain();
    write_reg(CFG_HISTORY_K, 5'd7);
    write_reg(CFG_FRAMES_IN_USE, 5'd31);
    add_random(250);
    drain();
    write_reg(CFG_HISTORY_K, 5'd3);
    write_reg(CFG_FRAMES_IN_USE, 5'd12);
    add_random(200);
    drain();
    write_reg(CFG_HISTORY_K, 5'h14);
    write_reg(CFG_FRAMES_IN_USE, 5'd16);
    add_random(220);
    drain();

    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/lkr_pkg.sv
rtl/lru_k_frame_replacer.sv
dv/lru_k_frame_replacer_tb.sv
